@@ rtl/rau_pkg.sv @@
package rau_pkg;

    // operand and internal widths
    localparam int W   = 16;
    localparam int DW  = 2 * W;
    localparam int NW  = 2 * W + 2;
    localparam int RNW = 33;
    localparam int RDW = 31;
    localparam int CW  = $clog2(DW + 1);

    // command codes
    localparam logic [2:0] CMD_MUL = 3'd0;
    localparam logic [2:0] CMD_DIV = 3'd1;
    localparam logic [2:0] CMD_ADD = 3'd2;
    localparam logic [2:0] CMD_SUB = 3'd3;
    localparam logic [2:0] CMD_LT  = 3'd4;
    localparam logic [2:0] CMD_GT  = 3'd5;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_N,
        OP_MUL_D,
        OP_G_RED,
        OP_G_DEN,
        OP_G_STEP,
        OP_G_NEXT,
        OP_DIV_LA,
        OP_MUL_L,
        OP_DIV_Q1,
        OP_MUL_T1,
        OP_DIV_Q2,
        OP_MUL_T2,
        OP_SUM,
        OP_DIV_RN,
        OP_SAVE_N,
        OP_DIV_RD,
        OP_FIN_RED,
        OP_FIN_CMP,
        OP_FIN_ERR,
        OP_FIN_ZERO
    } t_op;

    // status from datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       den_zero;
        logic       bnum_zero;
        logic       v_zero;
        logic       div_busy;
        logic       out_busy;
    } t_stat;

    // magnitude of an operand, widened
    function automatic logic [DW-1:0] mag_w(input logic signed [W-1:0] x);
        logic signed [DW-1:0] e;
        e = DW'(x);
        return x[W-1] ? DW'(-e) : DW'(e);
    endfunction

endpackage

@@ rtl/rau_if.sv @@
// request channel
interface rau_req_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      command;
    logic signed [rau_pkg::W-1:0]    a_num;
    logic signed [rau_pkg::W-1:0]    a_den;
    logic signed [rau_pkg::W-1:0]    b_num;
    logic signed [rau_pkg::W-1:0]    b_den;
    modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

// result channel
interface rau_res_if;
    logic                            valid;
    logic                            ready;
    logic signed [rau_pkg::RNW-1:0]  res_num;
    logic [rau_pkg::RDW-1:0]         res_den;
    logic                            is_less;
    logic                            is_greater;
    logic                            error;
    modport source (output valid, res_num, res_den, is_less, is_greater, error, input ready);
    modport sink   (input valid, res_num, res_den, is_less, is_greater, error, output ready);
endinterface

@@ rtl/rau_div.sv @@
module rau_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rau_pkg::DW-1:0]   i_dividend,
    input  logic [rau_pkg::DW-1:0]   i_divisor,
    output logic                     o_busy,
    output logic [rau_pkg::DW-1:0]   o_quot,
    output logic [rau_pkg::DW-1:0]   o_rem
);
    logic [rau_pkg::CW-1:0] r_cnt;
    logic [rau_pkg::DW-1:0] r_quo;
    logic [rau_pkg::DW-1:0] r_rem;
    logic [rau_pkg::DW-1:0] r_dvs;
    logic [rau_pkg::DW:0]   trial;

    // trial subtract of the shifted remainder
    assign trial = {r_rem, r_quo[rau_pkg::DW-1]} - {1'b0, r_dvs};

    // restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= rau_pkg::CW'(rau_pkg::DW);
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (!trial[rau_pkg::DW]) begin
                r_rem <= trial[rau_pkg::DW-1:0];
                r_quo <= {r_quo[rau_pkg::DW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[rau_pkg::DW-2:0], r_quo[rau_pkg::DW-1]};
                r_quo <= {r_quo[rau_pkg::DW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule

@@ rtl/rau_dp.sv @@
module rau_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rau_pkg::t_op                  i_op,
    output rau_pkg::t_stat                o_stat,
    input  logic [2:0]                    i_command,
    input  logic signed [rau_pkg::W-1:0]  i_a_num,
    input  logic signed [rau_pkg::W-1:0]  i_a_den,
    input  logic signed [rau_pkg::W-1:0]  i_b_num,
    input  logic signed [rau_pkg::W-1:0]  i_b_den,
    input  logic                          i_res_ready,
    output logic                          o_res_valid,
    output logic signed [rau_pkg::RNW-1:0] o_res_num,
    output logic [rau_pkg::RDW-1:0]       o_res_den,
    output logic                          o_is_less,
    output logic                          o_is_greater,
    output logic                          o_error
);
    localparam int DW = rau_pkg::DW;
    localparam int NW = rau_pkg::NW;

    logic [2:0]                  r_cmd;
    logic signed [rau_pkg::W-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [NW-1:0]        r_n, r_t1, r_t2;
    logic                        r_dneg;
    logic [DW-1:0]               r_dmag, r_u, r_v, r_l, r_qn;
    logic signed [rau_pkg::RNW-1:0] r_onum;
    logic [rau_pkg::RDW-1:0]     r_oden;
    logic                        r_oless, r_ogt, r_oerr, r_ov;

    logic signed [DW:0]          ma, mb;
    logic signed [2*DW+1:0]      prod;
    logic signed [NW-1:0]        pn;
    logic [DW-1:0]               n_mag, ad_mag, bd_mag;
    logic                        div_start, div_busy;
    logic [DW-1:0]               dvd, dvs, quot, rem;
    logic                        fin;

    assign ad_mag = rau_pkg::mag_w(r_ad);
    assign bd_mag = rau_pkg::mag_w(r_bd);
    assign n_mag  = r_n[NW-1] ? DW'(-r_n) : DW'(r_n);

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (i_op)
            rau_pkg::OP_MUL_N: begin
                ma = (DW+1)'(r_an);
                mb = (r_cmd == rau_pkg::CMD_DIV) ? (DW+1)'(r_bd) : (DW+1)'(r_bn);
            end
            rau_pkg::OP_MUL_D: begin
                ma = (DW+1)'(r_ad);
                mb = (r_cmd == rau_pkg::CMD_DIV) ? (DW+1)'(r_bn) : (DW+1)'(r_bd);
            end
            rau_pkg::OP_MUL_L: begin
                ma = {1'b0, quot};
                mb = {1'b0, bd_mag};
            end
            rau_pkg::OP_MUL_T1, rau_pkg::OP_MUL_T2: begin
                ma = (i_op == rau_pkg::OP_MUL_T1) ? (DW+1)'(r_an) : (DW+1)'(r_bn);
                mb = {1'b0, quot};
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = ma * mb;
    assign pn   = prod[NW-1:0];

    // divider operand select
    always_comb begin
        div_start = 1'b1;
        dvd = r_u;
        dvs = r_v;
        case (i_op)
            rau_pkg::OP_G_STEP: begin
                dvd = r_u;
                dvs = r_v;
            end
            rau_pkg::OP_DIV_LA: begin
                dvd = ad_mag;
                dvs = r_u;
            end
            rau_pkg::OP_DIV_Q1: begin
                dvd = r_l;
                dvs = ad_mag;
            end
            rau_pkg::OP_DIV_Q2: begin
                dvd = r_l;
                dvs = bd_mag;
            end
            rau_pkg::OP_DIV_RN: begin
                dvd = n_mag;
                dvs = r_u;
            end
            rau_pkg::OP_DIV_RD: begin
                dvd = r_dmag;
                dvs = r_u;
            end
            default: div_start = 1'b0;
        endcase
    end

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            rau_pkg::OP_LOAD: begin
                r_cmd <= i_command;
                r_an  <= i_a_num;
                r_ad  <= i_a_den;
                r_bn  <= i_b_num;
                r_bd  <= i_b_den;
            end
            rau_pkg::OP_MUL_N: r_n <= pn;
            rau_pkg::OP_MUL_D: begin
                r_dneg <= pn[NW-1];
                r_dmag <= pn[NW-1] ? DW'(-pn) : DW'(pn);
            end
            rau_pkg::OP_G_RED: begin
                r_u <= n_mag;
                r_v <= r_dmag;
            end
            rau_pkg::OP_G_DEN: begin
                r_u <= ad_mag;
                r_v <= bd_mag;
            end
            rau_pkg::OP_G_NEXT: begin
                r_u <= r_v;
                r_v <= rem;
            end
            rau_pkg::OP_MUL_L:  r_l <= pn[DW-1:0];
            rau_pkg::OP_MUL_T1: r_t1 <= r_ad[rau_pkg::W-1] ? -pn : pn;
            rau_pkg::OP_MUL_T2: r_t2 <= r_bd[rau_pkg::W-1] ? -pn : pn;
            rau_pkg::OP_SUM: begin
                r_n    <= (r_cmd == rau_pkg::CMD_ADD) ? r_t1 + r_t2 : r_t1 - r_t2;
                r_dneg <= 1'b0;
                r_dmag <= r_l;
            end
            rau_pkg::OP_SAVE_N: r_qn <= quot;
            default: ;
        endcase
    end

    assign fin = (i_op == rau_pkg::OP_FIN_RED) || (i_op == rau_pkg::OP_FIN_CMP)
              || (i_op == rau_pkg::OP_FIN_ERR) || (i_op == rau_pkg::OP_FIN_ZERO);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (fin) begin
            r_ov <= 1'b1;
        end else if (i_res_ready) begin
            r_ov <= 1'b0;
        end
        if (fin) begin
            r_onum  <= '0;
            r_oden  <= '0;
            r_oless <= 1'b0;
            r_ogt   <= 1'b0;
            r_oerr  <= 1'b0;
            case (i_op)
                rau_pkg::OP_FIN_RED: begin
                    r_onum <= (r_n[NW-1] != r_dneg) ? -rau_pkg::RNW'(r_qn)
                                                    : rau_pkg::RNW'(r_qn);
                    r_oden <= quot[rau_pkg::RDW-1:0];
                end
                rau_pkg::OP_FIN_CMP: begin
                    r_oless <= (r_cmd == rau_pkg::CMD_LT) && (r_t1 < r_t2);
                    r_ogt   <= (r_cmd == rau_pkg::CMD_GT) && (r_t1 > r_t2);
                end
                rau_pkg::OP_FIN_ERR: r_oerr <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.den_zero  = (r_ad == '0) || (r_bd == '0);
    assign o_stat.bnum_zero = (r_bn == '0);
    assign o_stat.v_zero    = (r_v == '0);
    assign o_stat.div_busy  = div_busy;
    assign o_stat.out_busy  = r_ov && !i_res_ready;

    assign o_res_valid  = r_ov;
    assign o_res_num    = r_onum;
    assign o_res_den    = r_oden;
    assign o_is_less    = r_oless;
    assign o_is_greater = r_ogt;
    assign o_error      = r_oerr;
endmodule

@@ rtl/rau_ctrl.sv @@
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_op   o_op
);
    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_MUL_N, ST_MUL_D, ST_GR_INIT, ST_GD_INIT,
        ST_G_TEST, ST_G_STEP, ST_G_NEXT, ST_LA_DIV, ST_MUL_L, ST_Q1_DIV,
        ST_T1, ST_Q2_DIV, ST_T2, ST_SUM, ST_RN_DIV, ST_SAVE_N, ST_RD_DIV,
        ST_WAIT, ST_FIN_RED, ST_FIN_CMP, ST_FIN_ERR, ST_FIN_ZERO
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic   r_red, n_red;

    assign o_req_ready = (r_state == ST_IDLE);

    // next state and operation
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_red   = r_red;
        o_op    = rau_pkg::OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_op    = rau_pkg::OP_LOAD;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.cmd > rau_pkg::CMD_GT) begin
                    n_state = ST_FIN_ZERO;
                end else if (i_stat.den_zero) begin
                    n_state = ST_FIN_ERR;
                end else if (i_stat.cmd == rau_pkg::CMD_DIV && i_stat.bnum_zero) begin
                    n_state = ST_FIN_ERR;
                end else if (i_stat.cmd <= rau_pkg::CMD_DIV) begin
                    n_state = ST_MUL_N;
                end else begin
                    n_state = ST_GD_INIT;
                end
            end
            ST_MUL_N: begin
                o_op    = rau_pkg::OP_MUL_N;
                n_state = ST_MUL_D;
            end
            ST_MUL_D: begin
                o_op    = rau_pkg::OP_MUL_D;
                n_state = ST_GR_INIT;
            end
            ST_GR_INIT: begin
                o_op    = rau_pkg::OP_G_RED;
                n_red   = 1'b1;
                n_state = ST_G_TEST;
            end
            ST_GD_INIT: begin
                o_op    = rau_pkg::OP_G_DEN;
                n_red   = 1'b0;
                n_state = ST_G_TEST;
            end
            ST_G_TEST: begin
                if (i_stat.v_zero) begin
                    n_state = r_red ? ST_RN_DIV : ST_LA_DIV;
                end else begin
                    n_state = ST_G_STEP;
                end
            end
            ST_G_STEP: begin
                o_op    = rau_pkg::OP_G_STEP;
                n_ret   = ST_G_NEXT;
                n_state = ST_WAIT;
            end
            ST_G_NEXT: begin
                o_op    = rau_pkg::OP_G_NEXT;
                n_state = ST_G_TEST;
            end
            ST_LA_DIV: begin
                o_op    = rau_pkg::OP_DIV_LA;
                n_ret   = ST_MUL_L;
                n_state = ST_WAIT;
            end
            ST_MUL_L: begin
                o_op    = rau_pkg::OP_MUL_L;
                n_state = ST_Q1_DIV;
            end
            ST_Q1_DIV: begin
                o_op    = rau_pkg::OP_DIV_Q1;
                n_ret   = ST_T1;
                n_state = ST_WAIT;
            end
            ST_T1: begin
                o_op    = rau_pkg::OP_MUL_T1;
                n_state = ST_Q2_DIV;
            end
            ST_Q2_DIV: begin
                o_op    = rau_pkg::OP_DIV_Q2;
                n_ret   = ST_T2;
                n_state = ST_WAIT;
            end
            ST_T2: begin
                o_op    = rau_pkg::OP_MUL_T2;
                n_state = (i_stat.cmd >= rau_pkg::CMD_LT) ? ST_FIN_CMP : ST_SUM;
            end
            ST_SUM: begin
                o_op    = rau_pkg::OP_SUM;
                n_state = ST_GR_INIT;
            end
            ST_RN_DIV: begin
                o_op    = rau_pkg::OP_DIV_RN;
                n_ret   = ST_SAVE_N;
                n_state = ST_WAIT;
            end
            ST_SAVE_N: begin
                o_op    = rau_pkg::OP_SAVE_N;
                n_state = ST_RD_DIV;
            end
            ST_RD_DIV: begin
                o_op    = rau_pkg::OP_DIV_RD;
                n_ret   = ST_FIN_RED;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = r_ret;
                end
            end
            ST_FIN_RED, ST_FIN_CMP, ST_FIN_ERR, ST_FIN_ZERO: begin
                if (!i_stat.out_busy) begin
                    case (r_state)
                        ST_FIN_RED: o_op = rau_pkg::OP_FIN_RED;
                        ST_FIN_CMP: o_op = rau_pkg::OP_FIN_CMP;
                        ST_FIN_ERR: o_op = rau_pkg::OP_FIN_ERR;
                        default:    o_op = rau_pkg::OP_FIN_ZERO;
                    endcase
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_red   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_red   <= n_red;
        end
    end
endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// an error or unused command goes straight to its result; every other command runs
// gcd remainder steps and further divisions on the shared 32-bit bit-serial
// divider, which sets how long a request takes
// throughput: one request at a time; a new request is taken while a result waits
// reset: synchronous active-low i_rst_n returns the controller to idle and
// empties the result register
module rational_arithmetic_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_req_if.sink   i_req,
    rau_res_if.source o_res
);
    rau_pkg::t_op   op;
    rau_pkg::t_stat stat;

    // controller
    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_op        (op)
    );

    // datapath
    rau_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .o_stat       (stat),
        .i_command    (i_req.command),
        .i_a_num      (i_req.a_num),
        .i_a_den      (i_req.a_den),
        .i_b_num      (i_req.b_num),
        .i_b_den      (i_req.b_den),
        .i_res_ready  (o_res.ready),
        .o_res_valid  (o_res.valid),
        .o_res_num    (o_res.res_num),
        .o_res_den    (o_res.res_den),
        .o_is_less    (o_res.is_less),
        .o_is_greater (o_res.is_greater),
        .o_error      (o_res.error)
    );
endmodule

@@ sim/tb_pkg.sv @@
`timescale 1ns / 1ps
package tb_pkg;

    // one expected result of the arithmetic unit
    typedef struct packed {
        logic signed [32:0] res_num;
        logic [30:0]        res_den;
        logic               is_less;
        logic               is_greater;
        logic               error;
    } t_fraction_result;

endpackage

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

    logic i_clk;
    logic i_rst_n;

    rau_req_if req_bus ();
    rau_res_if res_bus ();

    rational_arithmetic_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_res   (res_bus.source)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    tb_pkg::t_fraction_result expected_results[$];
    int unsigned      error_count;
    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    int unsigned      quiet_cycles;

    localparam int unsigned QUIET_LIMIT = 100000;

    // mismatch report
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [63:0] gcd64(input logic [63:0] u, input logic [63:0] v);
        logic [63:0] t;
        while (v != 0) begin
            t = v;
            v = u % v;
            u = t;
        end
        return u;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // reduce num bits over signed denominator into lowest terms
    function automatic tb_pkg::t_fraction_result reduce_fraction(input logic [63:0] nbits,
                                                                 input logic dneg,
                                                                 input logic [63:0] dmag);
        tb_pkg::t_fraction_result r;
        logic             nneg;
        logic [63:0]      nm;
        logic [63:0]      g;
        r = '0;
        nneg = nbits[63];
        nm = nneg ? -nbits : nbits;
        g = gcd64(nm, dmag);
        nm = nm / g;
        dmag = dmag / g;
        r.res_num = 33'((nneg != dneg) ? -nm : nm);
        r.res_den = 31'(dmag);
        return r;
    endfunction

    // bring x/y over common denominator l
    function automatic logic [63:0] scale_term(input logic signed [63:0] x,
                                               input logic signed [63:0] y,
                                               input logic [63:0] l);
        logic [63:0] p;
        p = 64'(x) * (l / abs64(y));
        return y < 0 ? -p : p;
    endfunction

    function automatic tb_pkg::t_fraction_result predict_fraction(input logic [2:0] cmd,
        input logic signed [15:0] an16, input logic signed [15:0] ad16,
        input logic signed [15:0] bn16, input logic signed [15:0] bd16);
        tb_pkg::t_fraction_result r;
        logic signed [63:0] an, ad, bn, bd, d;
        logic [63:0]        l, t1, t2;
        r = '0;
        an = 64'(an16);
        ad = 64'(ad16);
        bn = 64'(bn16);
        bd = 64'(bd16);
        if (cmd > rau_pkg::CMD_GT) return r;
        if (ad == 0 || bd == 0) begin
            r.error = 1'b1;
            return r;
        end
        case (cmd)
            rau_pkg::CMD_MUL: begin
                d = ad * bd;
                return reduce_fraction(64'(an * bn), d < 0, abs64(d));
            end
            rau_pkg::CMD_DIV: begin
                d = ad * bn;
                if (d == 0) begin
                    r.error = 1'b1;
                    return r;
                end
                return reduce_fraction(64'(an * bd), d < 0, abs64(d));
            end
            default: begin
                l = (abs64(ad) / gcd64(abs64(ad), abs64(bd))) * abs64(bd);
                t1 = scale_term(an, ad, l);
                t2 = scale_term(bn, bd, l);
                if (cmd == rau_pkg::CMD_ADD) return reduce_fraction(t1 + t2, 1'b0, l);
                if (cmd == rau_pkg::CMD_SUB) return reduce_fraction(t1 - t2, 1'b0, l);
                if (cmd == rau_pkg::CMD_LT) r.is_less = $signed(t1) < $signed(t2);
                else r.is_greater = $signed(t1) > $signed(t2);
                return r;
            end
        endcase
    endfunction

    // send one request and record its expected result
    task automatic send_request(input logic [2:0] cmd, input logic [15:0] an,
                                input logic [15:0] ad, input logic [15:0] bn,
                                input logic [15:0] bd);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.command <= cmd;
        req_bus.a_num   <= an;
        req_bus.a_den   <= ad;
        req_bus.b_num   <= bn;
        req_bus.b_den   <= bd;
        expected_results.push_back(predict_fraction(cmd, an, ad, bn, bd));
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        tb_pkg::t_fraction_result want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(res_bus.res_num), 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (res_bus.res_num !== want.res_num)
                        report_mismatch("res_num", 64'(res_bus.res_num), 64'(want.res_num));
                    if (res_bus.res_den !== want.res_den)
                        report_mismatch("res_den", 64'(res_bus.res_den), 64'(want.res_den));
                    if (res_bus.is_less !== want.is_less)
                        report_mismatch("is_less", 64'(res_bus.is_less), 64'(want.is_less));
                    if (res_bus.is_greater !== want.is_greater)
                        report_mismatch("is_greater", 64'(res_bus.is_greater),
                                        64'(want.is_greater));
                    if (res_bus.error !== want.error)
                        report_mismatch("error", 64'(res_bus.error), 64'(want.error));
                end
            end
            res_bus.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [15:0] random_operand();
        case ($urandom_range(5))
            0: return 16'($urandom_range(15)) - 16'd8;
            1: return 16'h8000 + 16'($urandom_range(3));
            2: return 16'h7fff - 16'($urandom_range(3));
            3: return 16'($urandom_range(255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    // drop the request and wait for every expected result
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic test_directed();
        logic [2:0] cmd;
        for (int c = 0; c <= 7; c++) begin
            cmd = 3'(c);
            send_request(cmd, 16'sd3, 16'sd4, -16'sd5, 16'sd6);
        end
        // zero denominators, divide by zero fraction, zero numerator
        send_request(rau_pkg::CMD_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd2);
        send_request(rau_pkg::CMD_MUL, 16'sd1, 16'sd2, 16'sd1, 16'sd0);
        send_request(rau_pkg::CMD_DIV, 16'sd7, 16'sd3, 16'sd0, 16'sd5);
        send_request(rau_pkg::CMD_MUL, 16'sd0, -16'sd9, 16'sd4, 16'sd7);
        send_request(rau_pkg::CMD_SUB, 16'sd5, 16'sd3, 16'sd5, 16'sd3);
        // operand extremes
        send_request(rau_pkg::CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        send_request(rau_pkg::CMD_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
        send_request(rau_pkg::CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h7ffe);
        send_request(rau_pkg::CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8001);
        send_request(rau_pkg::CMD_LT, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_request(rau_pkg::CMD_GT, 16'h7fff, 16'hffff, 16'h8000, 16'h0001);
        send_request(rau_pkg::CMD_GT, 16'sd1, 16'sd2, 16'sd2, 16'sd4);
        send_request(7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    endtask

    task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                               input int unsigned stall_pct);
        logic [2:0] cmd;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int unsigned i = 0; i < count; i++) begin
            cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
            send_request(cmd, random_operand(), random_operand(), random_operand(),
                         random_operand());
        end
    endtask

    // hold off until the pipeline is empty, then continue
    task automatic test_drain_pause();
        wait_drained();
        send_request(rau_pkg::CMD_ADD, 16'sd1, 16'sd3, 16'sd1, 16'sd6);
    endtask

    initial begin
        error_count    = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n         = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.command = '0;
        req_bus.a_num   = '0;
        req_bus.a_den   = '0;
        req_bus.b_num   = '0;
        req_bus.b_den   = '0;
        res_bus.ready   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(350, 0, 0);
        test_drain_pause();
        test_random(350, 76, 0);
        test_random(350, 0, 76);
        test_random(350, 21, 21);

        send_idle_pct = 0;
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
